>>> src/ppcf_pkg.sv
// Package for the palette plane consistency filter.
// Holds the request/response payload types, the 565 channel helpers and
// sizing constants. No dependencies.
`timescale 1ns / 1ps

package ppcf_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int COUNT_W         = $clog2(PALETTE_ENTRIES + 1);
   localparam int INDEX_W         = 8;
   localparam int COLOR_W         = 16;
   localparam int CHAN_W          = 5;
   localparam int SQSUM_W         = 2 * CHAN_W + 2;
   localparam int PLANES          = 6;

   localparam logic [1:0]         MODE_FILTER    = 2'd2;
   localparam logic [INDEX_W-1:0] LAST_INDEX     = INDEX_W'(PALETTE_ENTRIES - 1);
   localparam logic [INDEX_W-1:0] FIRST_INDEX    = '0;
   localparam logic [COUNT_W-1:0] COUNT_LIMIT    = COUNT_W'(PALETTE_ENTRIES);
   localparam logic [SQSUM_W-1:0] DARK_LIMIT     = SQSUM_W'(32);
   localparam logic [SQSUM_W-1:0] DIST_LIMIT     = SQSUM_W'(16);
   localparam logic [COLOR_W-1:0] NO_INDEX       = 16'hffff;

   typedef struct packed {
      logic [INDEX_W-1:0] entry_index;
      logic [COLOR_W-1:0] base_color;
      logic [COLOR_W-1:0] plane_one;
      logic [COLOR_W-1:0] plane_two;
      logic [COLOR_W-1:0] plane_three;
      logic [COLOR_W-1:0] plane_four;
      logic [COLOR_W-1:0] plane_five;
      logic [COLOR_W-1:0] plane_six;
      logic [COLOR_W-1:0] replacement_color;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] new_entry;
      logic               cleared;
      logic               run_done;
      logic [COLOR_W-1:0] first_cleared_index;
      logic               index_written;
      logic [7:0]         cleared_count;
   } rsp_type;

   // Verdict for one entry, classify -> stats/top.
   typedef struct packed {
      logic               active;
      logic               cleared;
      logic [COLOR_W-1:0] new_entry;
   } verdict_type;

   // End-of-run statistics, stats -> top.
   typedef struct packed {
      logic               run_done;
      logic [COLOR_W-1:0] first_cleared_index;
      logic               index_written;
      logic [7:0]         cleared_count;
   } report_type;

   function automatic logic [CHAN_W-1:0] chan_b(input logic [COLOR_W-1:0] c);
      return c[4:0];
   endfunction

   function automatic logic [CHAN_W-1:0] chan_g(input logic [COLOR_W-1:0] c);
      return c[10:6];
   endfunction

   function automatic logic [CHAN_W-1:0] chan_r(input logic [COLOR_W-1:0] c);
      return c[15:11];
   endfunction

   function automatic logic [2*CHAN_W-1:0] sq_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
      logic [CHAN_W-1:0] d;
      d = (a > b) ? (a - b) : (b - a);
      return (2*CHAN_W)'(d) * (2*CHAN_W)'(d);
   endfunction

endpackage

>>> src/ppcf_bus.sv
// Valid/ready channel interfaces for the palette filter requests and
// responses. Depends on ppcf_pkg for the payload types.
`timescale 1ns / 1ps

interface ppcf_req_bus;
   logic              valid;
   logic              ready;
   ppcf_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface ppcf_rsp_bus;
   logic              valid;
   logic              ready;
   ppcf_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> src/ppcf_classify.sv
// Per-entry decision in filter mode: dark base or any plane too far from base clears it.
// Purely combinational; depends on ppcf_pkg.
`timescale 1ns / 1ps

module ppcf_classify (
   input  ppcf_pkg::req_type     item,
   input  logic [1:0]            texture_mode,
   output ppcf_pkg::verdict_type verdict
);
   import ppcf_pkg::*;

   logic [COLOR_W-1:0] planes [PLANES];
   logic [PLANES-1:0]  plane_far;
   logic [SQSUM_W-1:0] base_mag;
   logic               dark;
   logic               far;

   assign planes[0] = item.plane_one;
   assign planes[1] = item.plane_two;
   assign planes[2] = item.plane_three;
   assign planes[3] = item.plane_four;
   assign planes[4] = item.plane_five;
   assign planes[5] = item.plane_six;

   always_comb begin
      for (int k = 0; k < PLANES; k++) begin
         plane_far[k] = (SQSUM_W'(sq_diff(chan_b(planes[k]), chan_b(item.base_color)))
                       + SQSUM_W'(sq_diff(chan_g(planes[k]), chan_g(item.base_color)))
                       + SQSUM_W'(sq_diff(chan_r(planes[k]), chan_r(item.base_color))))
                       > DIST_LIMIT;
      end
   end

   // Squared magnitude of the base is its distance from black.
   assign base_mag = SQSUM_W'(sq_diff(chan_b(item.base_color), '0))
                   + SQSUM_W'(sq_diff(chan_g(item.base_color), '0))
                   + SQSUM_W'(sq_diff(chan_r(item.base_color), '0));
   assign dark     = base_mag < DARK_LIMIT;
   assign far      = dark || (|plane_far);

   always_comb begin
      verdict.active  = (texture_mode == MODE_FILTER);
      verdict.cleared = verdict.active && far;
      if (!verdict.active) begin
         verdict.new_entry = item.base_color;
      end else if (far) begin
         verdict.new_entry = '0;
      end else begin
         verdict.new_entry = item.replacement_color;
      end
   end

endmodule

>>> src/ppcf_stats.sv
// Run statistics: cleared count and first cleared index, restarted by
// entry 0 and reported on the last entry. Depends on ppcf_pkg.
`timescale 1ns / 1ps

module ppcf_stats (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  logic [ppcf_pkg::INDEX_W-1:0]     entry_index,
   input  ppcf_pkg::verdict_type            verdict,
   output ppcf_pkg::report_type             report
);
   import ppcf_pkg::*;

   logic [COUNT_W-1:0] total_ff, total_in, total_base;
   logic [INDEX_W-1:0] first_ff, first_in, first_base;
   logic               any_ff, any_in, any_base;
   logic               restart;

   assign restart = (entry_index == FIRST_INDEX);

   always_comb begin
      total_base = restart ? '0 : total_ff;
      first_base = restart ? '0 : first_ff;
      any_base   = restart ? 1'b0 : any_ff;

      total_in = total_base;
      first_in = first_base;
      any_in   = any_base;
      if (verdict.cleared) begin
         if (total_base < COUNT_LIMIT) begin
            total_in = total_base + COUNT_W'(1);
         end
         if (!any_base) begin
            any_in   = 1'b1;
            first_in = entry_index;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         first_ff <= '0;
         any_ff   <= 1'b0;
      end else if (advance) begin
         total_ff <= total_in;
         first_ff <= first_in;
         any_ff   <= any_in;
      end
   end

   always_comb begin
      report.run_done            = (entry_index == LAST_INDEX);
      report.first_cleared_index = '0;
      report.index_written       = 1'b0;
      report.cleared_count       = '0;
      if (report.run_done) begin
         if (verdict.active) begin
            report.first_cleared_index = any_in ? COLOR_W'(first_in) : NO_INDEX;
            report.index_written       = 1'b1;
            // A full count reads as zero.
            report.cleared_count       = (total_in >= COUNT_LIMIT) ? '0 : 8'(total_in);
         end else begin
            report.first_cleared_index = NO_INDEX;
         end
      end
   end

endmodule

>>> src/palette_plane_consistency_filter.sv
// Top level of the palette plane consistency filter.
// Depends on ppcf_pkg, ppcf_bus, ppcf_classify and ppcf_stats.
//
// Usage:
//   req_bus carries one palette column per request: entry index, base
//   colour, six shade-plane colours and a replacement colour (565 layout).
//   rsp_bus returns one response per request, in order: the new entry, a
//   cleared flag and, on the last entry of a run, the run statistics.
//   csr_write_enable/csr_write_data set texture_mode; write it only while
//   no request is in flight. Filtering runs only in mode 2.
//   A request passes through the input register, then the response
//   register, before its response is valid. The classifier between
//   them is a single pass of six narrow distance checks, so one request
//   is accepted every cycle while the receiver takes responses.
//   When the receiver stalls the response register holds, the input
//   register fills behind it and req_bus.ready drops; with both full the
//   block waits without losing anything.
//   Reset (synchronous, active high) empties both registers, sets the
//   mode to 0 and clears the run statistics.
`timescale 1ns / 1ps

module palette_plane_consistency_filter (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   ppcf_req_bus.sink   req_bus,
   ppcf_rsp_bus.source rsp_bus
);
   import ppcf_pkg::*;

   logic [1:0]  texture_mode_ff;
   req_type     item_ff;
   logic        item_valid_ff;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff;
   logic        rsp_free;
   logic        advance;
   verdict_type verdict;
   report_type  report;

   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;
   assign advance  = item_valid_ff && rsp_free;

   assign req_bus.ready   = !item_valid_ff || rsp_free;
   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         texture_mode_ff <= '0;
      end else if (csr_write_enable) begin
         texture_mode_ff <= csr_write_data;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_bus.ready) begin
         item_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready && req_bus.valid) begin
         item_ff <= req_bus.payload;
      end
   end

   ppcf_classify u_classify (
      .item         (item_ff),
      .texture_mode (texture_mode_ff),
      .verdict      (verdict)
   );

   ppcf_stats u_stats (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .entry_index (item_ff.entry_index),
      .verdict     (verdict),
      .report      (report)
   );

   always_comb begin
      rsp_in.new_entry           = verdict.new_entry;
      rsp_in.cleared             = verdict.cleared;
      rsp_in.run_done            = report.run_done;
      rsp_in.first_cleared_index = report.first_cleared_index;
      rsp_in.index_written       = report.index_written;
      rsp_in.cleared_count       = report.cleared_count;
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> src/ppcf_checker.sv
// Port-level checks for the palette plane consistency filter, bound to the
// top level. Depends on ppcf_pkg for the response constants.
`timescale 1ns / 1ps

module ppcf_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [ppcf_pkg::COLOR_W-1:0]   new_entry,
   input logic                           cleared,
   input logic                           run_done,
   input logic [ppcf_pkg::COLOR_W-1:0]   first_cleared_index,
   input logic                           index_written,
   input logic [7:0]                     cleared_count
);
   import ppcf_pkg::*;

   // No response right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cleared |-> new_entry == '0)
      else $error("cleared entry is not zero");

   a_mid_run_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !run_done |->
         first_cleared_index == '0 && !index_written && cleared_count == '0)
      else $error("statistics shown before end of run");

   a_idle_stats: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_done && !index_written |->
         first_cleared_index == NO_INDEX && cleared_count == '0 && !cleared)
      else $error("statistics reported outside filter mode");

endmodule

bind palette_plane_consistency_filter ppcf_checker u_ppcf_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_bus.valid),
   .rsp_ready           (rsp_bus.ready),
   .new_entry           (rsp_bus.payload.new_entry),
   .cleared             (rsp_bus.payload.cleared),
   .run_done            (rsp_bus.payload.run_done),
   .first_cleared_index (rsp_bus.payload.first_cleared_index),
   .index_written       (rsp_bus.payload.index_written),
   .cleared_count       (rsp_bus.payload.cleared_count)
);

>>> tb/ppcf_result_check.sv
// Response checker for the palette plane consistency filter testbench.
// Watches the request, response and register ports, predicts each response
// and compares it field by field. Depends on ppcf_pkg and ppcf_bus.
`timescale 1ns / 1ps

module ppcf_result_check (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_write_data,
   ppcf_req_bus        req_bus,
   ppcf_rsp_bus        rsp_bus,
   output int          mismatches,
   output int          outstanding,
   output int          checked,
   output int          clears_seen,
   output int          reports_seen
);
   import ppcf_pkg::*;

   localparam int REPORT_LIMIT = 10;

   rsp_type              expected_q[$];
   logic [1:0]           mode;
   logic [COUNT_W-1:0]   clear_tally;
   logic [INDEX_W-1:0]   first_clear_at;
   logic                 seen_clear;

   initial begin
      mismatches   = 0;
      outstanding  = 0;
      checked      = 0;
      clears_seen  = 0;
      reports_seen = 0;
   end

   function automatic int chan_dist2(input logic [4:0] a, input logic [4:0] b);
      int d;
      d = int'(a) - int'(b);
      return d * d;
   endfunction

   // Base too dim to shade: squared magnitude below 32.
   function automatic bit dim_base(input logic [15:0] c);
      return chan_dist2(c[4:0], 5'd0) + chan_dist2(c[10:6], 5'd0)
           + chan_dist2(c[15:11], 5'd0) < 32;
   endfunction

   // Bit 5 sits between the blue and green fields and takes no part.
   function automatic bit plane_off(input logic [15:0] base, input logic [15:0] plane);
      return chan_dist2(plane[4:0], base[4:0]) + chan_dist2(plane[10:6], base[10:6])
           + chan_dist2(plane[15:11], base[15:11]) > 16;
   endfunction

   task automatic predict_entry(input req_type r);
      rsp_type e;
      bit      far;
      if (r.entry_index == FIRST_INDEX) begin
         clear_tally    = '0;
         first_clear_at = '0;
         seen_clear     = 1'b0;
      end
      e = '0;
      e.new_entry = r.base_color;
      if (mode == MODE_FILTER) begin
         far = dim_base(r.base_color)
            || plane_off(r.base_color, r.plane_one)
            || plane_off(r.base_color, r.plane_two)
            || plane_off(r.base_color, r.plane_three)
            || plane_off(r.base_color, r.plane_four)
            || plane_off(r.base_color, r.plane_five)
            || plane_off(r.base_color, r.plane_six);
         if (far) begin
            e.new_entry = '0;
            e.cleared   = 1'b1;
            clears_seen++;
            // saturate the tally; a full count reads back as zero
            if (clear_tally < COUNT_LIMIT) clear_tally = clear_tally + COUNT_W'(1);
            if (!seen_clear) begin
               seen_clear     = 1'b1;
               first_clear_at = r.entry_index;
            end
         end else begin
            e.new_entry = r.replacement_color;
         end
      end
      if (r.entry_index == LAST_INDEX) begin
         reports_seen++;
         e.run_done = 1'b1;
         e.first_cleared_index = NO_INDEX;
         if (mode == MODE_FILTER) begin
            if (seen_clear) e.first_cleared_index = {8'h00, first_clear_at};
            e.index_written = 1'b1;
            e.cleared_count = (clear_tally >= COUNT_LIMIT) ? 8'd0 : clear_tally[7:0];
         end
      end
      expected_q.push_back(e);
   endtask

   task automatic check_field(input string field, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT)
            $display("response %0d: %s expected %h, got %h", checked, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type got;
      rsp_type want;
      if (reset) begin
         expected_q.delete();
         mode           = 2'd0;
         clear_tally    = '0;
         first_clear_at = '0;
         seen_clear     = 1'b0;
      end else begin
         if (csr_write_enable) mode = csr_write_data;
         if (req_bus.valid && req_bus.ready) predict_entry(req_bus.payload);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = rsp_bus.payload;
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("response %0d arrived with no request pending: %h", checked, got);
            end else begin
               want = expected_q.pop_front();
               check_field("new_entry", got.new_entry, want.new_entry);
               check_field("cleared", 16'(got.cleared), 16'(want.cleared));
               check_field("run_done", 16'(got.run_done), 16'(want.run_done));
               check_field("first_cleared_index", got.first_cleared_index,
                           want.first_cleared_index);
               check_field("index_written", 16'(got.index_written),
                           16'(want.index_written));
               check_field("cleared_count", 16'(got.cleared_count),
                           16'(want.cleared_count));
            end
            checked++;
         end
      end
      outstanding = expected_q.size();
   end

endmodule

>>> tb/palette_plane_consistency_filter_tb.sv
// Top of the palette plane consistency filter testbench: clock, reset,
// request and register stimulus, response pacing and the verdict.
// Depends on ppcf_pkg, ppcf_bus, ppcf_result_check and the filter RTL.
`timescale 1ns / 1ps

module palette_plane_consistency_filter_tb;
   import ppcf_pkg::*;

   localparam logic [1:0] MODE_BYPASS_LOW  = 2'd0;
   localparam logic [1:0] MODE_BYPASS_MID  = 2'd1;
   localparam logic [1:0] MODE_BYPASS_HIGH = 2'd3;
   localparam int         CYCLE_LIMIT      = 300000;
   localparam int         SQUEEZE_CYCLES   = 120;

   typedef enum {COL_TYPICAL, COL_DARK, COL_NOISE} column_kind_type;

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [1:0] csr_write_data;
   bit         squeeze_req;
   bit         squeeze_done;
   int         tx_calm;
   int         sent;
   int         mismatches;
   int         outstanding;
   int         checked;
   int         clears_seen;
   int         reports_seen;

   ppcf_req_bus req_bus ();
   ppcf_rsp_bus rsp_bus ();

   palette_plane_consistency_filter dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus)
   );

   ppcf_result_check checker_i (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .mismatches       (mismatches),
      .outstanding      (outstanding),
      .checked          (checked),
      .clears_seen      (clears_seen),
      .reports_seen     (reports_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] rgb(input int r, input int g, input int b);
      return {5'(r), 1'b0, 5'(g), 5'(b)};
   endfunction

   function automatic int idle_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic int jitter(input logic [4:0] v, input int spread);
      int n;
      n = int'(v) + $urandom_range(0, 2 * spread) - spread;
      if (n < 0) n = 0;
      if (n > 31) n = 31;
      return n;
   endfunction

   // Mostly a shade close to the base; now and then one near the limit or unrelated.
   function automatic logic [15:0] nearby(input logic [15:0] base);
      int          roll;
      int          spread;
      logic [15:0] p;
      roll = $urandom_range(0, 99);
      if (roll >= 95) return 16'($urandom);
      spread = (roll < 85) ? 2 : 4;
      p = rgb(jitter(base[15:11], spread), jitter(base[10:6], spread),
              jitter(base[4:0], spread));
      p[5] = 1'($urandom_range(0, 1));
      return p;
   endfunction

   function automatic req_type column(input logic [7:0] idx, input logic [15:0] base,
                                      input logic [15:0] plane, input logic [15:0] repl);
      req_type c;
      c.entry_index       = idx;
      c.base_color        = base;
      c.plane_one         = plane;
      c.plane_two         = plane;
      c.plane_three       = plane;
      c.plane_four        = plane;
      c.plane_five        = plane;
      c.plane_six         = plane;
      c.replacement_color = repl;
      return c;
   endfunction

   function automatic req_type random_column(input logic [7:0] idx,
                                             input column_kind_type kind);
      req_type     c;
      logic [15:0] base;
      if (kind == COL_NOISE) begin
         c = column(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
         c.plane_two   = 16'($urandom);
         c.plane_three = 16'($urandom);
         c.plane_four  = 16'($urandom);
         c.plane_five  = 16'($urandom);
         c.plane_six   = 16'($urandom);
         return c;
      end
      if (kind == COL_DARK)
         base = rgb($urandom_range(0, 2), $urandom_range(0, 2), $urandom_range(0, 4));
      else if ($urandom_range(0, 9) == 0)
         base = rgb($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4));
      else
         base = 16'($urandom);
      base[5] = 1'($urandom_range(0, 1));
      c.entry_index       = idx;
      c.base_color        = base;
      c.plane_one         = nearby(base);
      c.plane_two         = nearby(base);
      c.plane_three       = nearby(base);
      c.plane_four        = nearby(base);
      c.plane_five        = nearby(base);
      c.plane_six         = nearby(base);
      c.replacement_color = 16'($urandom);
      return c;
   endfunction

   // Leaves valid high after the handshake so back-to-back requests need no gap.
   task automatic send_request(input req_type col);
      int gap;
      if (tx_calm > 0) begin
         tx_calm--;
         gap = 0;
      end else begin
         gap = idle_gap();
         if ($urandom_range(0, 39) == 0) tx_calm = $urandom_range(20, 60);
      end
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.payload <= col;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent++;
   endtask

   // Mostly whole runs (restart, random entries, last entry), some stray requests.
   task automatic send_runs(input int count);
      int done_items;
      int span;
      int k;
      done_items = 0;
      while (done_items < count) begin
         if ($urandom_range(0, 4) == 0) begin
            send_request(random_column(8'd0, COL_NOISE));
            done_items++;
         end else begin
            span = $urandom_range(0, 20);
            send_request(random_column(FIRST_INDEX, COL_TYPICAL));
            for (k = 0; k < span; k++)
               send_request(random_column(8'($urandom_range(1, 254)), COL_TYPICAL));
            send_request(random_column(LAST_INDEX, COL_TYPICAL));
            done_items += span + 2;
         end
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_mode(input logic [1:0] m);
      csr_write_enable <= 1'b1;
      csr_write_data   <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : rsp_pacing
      int gap_left;
      int rx_calm;
      gap_left = 0;
      rx_calm  = 0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (squeeze_req && !squeeze_done) begin
            // hold off long enough for the block to back up into its input
            rsp_bus.ready <= 1'b0;
            repeat (SQUEEZE_CYCLES - 1) @(posedge clock);
            squeeze_done = 1'b1;
         end else if (gap_left > 0) begin
            rsp_bus.ready <= 1'b0;
            gap_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (rx_calm > 0) begin
               rx_calm--;
            end else begin
               gap_left = idle_gap();
               if ($urandom_range(0, 39) == 0) rx_calm = $urandom_range(20, 60);
            end
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("no finish after %0d cycles, %0d responses still due", cycles, outstanding);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus
      req_type col;
      int      k;
      tx_calm = 0;
      sent    = 0;
      reset            <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 2'd0;
      req_bus.valid    <= 1'b0;
      req_bus.payload  <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_mode(MODE_FILTER);
      send_request(column(8'd0, 16'h0000, 16'h0000, 16'hffff));
      send_request(column(8'd1, 16'hffff, 16'hffff, 16'h1234));
      // squared magnitude exactly 32 survives, 30 is too dim
      send_request(column(8'd2, rgb(0, 4, 4), rgb(0, 4, 4), 16'ha5a5));
      send_request(column(8'd3, rgb(1, 2, 5), rgb(1, 2, 5), 16'h5a5a));
      // distance exactly 16 stays, 17 clears
      send_request(column(8'd4, 16'hffff, rgb(31, 31, 27), 16'h0f0f));
      col = column(8'd5, 16'hffff, 16'hffff, 16'hf0f0);
      col.plane_six = rgb(31, 30, 27);
      send_request(col);
      send_request(column(8'd6, 16'hffdf, 16'hffff, 16'h0000));
      send_request(column(8'd7, rgb(16, 16, 16), rgb(20, 16, 16), 16'h7777));
      col = column(8'd8, rgb(16, 16, 16), rgb(16, 16, 16), 16'h8888);
      col.plane_one = rgb(21, 16, 16);
      send_request(col);
      col = column(8'd9, 16'hffff, 16'hffff, 16'h1111);
      col.plane_three = 16'h0000;
      send_request(col);
      send_request(column(LAST_INDEX, 16'hffff, 16'hffff, 16'h2222));
      send_request(column(FIRST_INDEX, 16'hffff, 16'hffff, 16'h3333));
      send_request(column(LAST_INDEX, rgb(0, 4, 4), rgb(0, 4, 4), 16'h4444));
      // last entry again without a restart, cleared itself
      send_request(column(LAST_INDEX, 16'h0000, 16'h0000, 16'h0000));
      settle();

      set_mode(MODE_BYPASS_HIGH);
      send_request(column(LAST_INDEX, 16'h0000, 16'h0000, 16'hffff));
      send_runs(60);
      settle();

      set_mode(MODE_BYPASS_LOW);
      send_runs(60);
      settle();

      set_mode(MODE_BYPASS_MID);
      send_runs(40);
      settle();

      // one long run of dim entries drives the tally past its limit
      set_mode(MODE_FILTER);
      send_request(random_column(FIRST_INDEX, COL_DARK));
      for (k = 0; k < 258; k++)
         send_request(random_column(8'($urandom_range(1, 254)), COL_DARK));
      send_request(random_column(LAST_INDEX, COL_DARK));
      send_request(random_column(8'($urandom_range(1, 254)), COL_DARK));
      send_request(random_column(LAST_INDEX, COL_TYPICAL));

      squeeze_req = 1'b1;
      send_runs(270);
      settle();
      repeat (8) @(posedge clock);

      $display("%0d requests over modes 0 to 3, %0d responses checked", sent, checked);
      $display("%0d entries cleared, %0d end-of-run reports", clears_seen, reports_seen);
      if (mismatches == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
